>>> rtl/rwsc_pkg.sv
// Shared types and codes for the rain wiper speed controller.
// Depends on nothing; every other file in rtl imports it.
`timescale 1ns / 1ps

package rwsc_pkg;

  // Operation codes
  localparam logic [2:0] OP_READING    = 3'd0;
  localparam logic [2:0] OP_TICK       = 3'd1;
  localparam logic [2:0] OP_SET_SPEED  = 3'd2;
  localparam logic [2:0] OP_SET_SPRAY  = 3'd3;
  localparam logic [2:0] OP_SPRAY_WIPE = 3'd4;

  // Wiper speed codes
  localparam logic [1:0] SPD_OFF  = 2'd0;
  localparam logic [1:0] SPD_LOW  = 2'd1;
  localparam logic [1:0] SPD_MED  = 2'd2;
  localparam logic [1:0] SPD_HIGH = 2'd3;

  // Spray codes
  localparam logic [1:0] SPRAY_OFF   = 2'd0;
  localparam logic [1:0] SPRAY_LIGHT = 2'd1;
  localparam logic [1:0] SPRAY_HEAVY = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_ADDR_W-1:0] REG_OFF_LEVEL      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LOW_LEVEL      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MEDIUM_LEVEL   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TURN_OFF_DELAY = 2'd3;

  // Reset values of the configuration registers
  localparam logic [9:0] OFF_LEVEL_RST      = 10'd800;
  localparam logic [9:0] LOW_LEVEL_RST      = 10'd500;
  localparam logic [9:0] MEDIUM_LEVEL_RST   = 10'd200;
  localparam logic [7:0] TURN_OFF_DELAY_RST = 8'd10;

  localparam logic [7:0] ELAPSED_MAX = 8'd255;

  typedef struct packed {
    logic [2:0] op;
    logic [9:0] light_level;
    logic       reading_valid;
    logic       rain_burst;
    logic [1:0] new_speed;
    logic [1:0] spray_choice;
  } in_item_t;

  typedef struct packed {
    logic [1:0] wiper_speed;
    logic [1:0] spray_state;
    logic       waiting_off;
    logic [7:0] remaining_seconds;
  } out_item_t;

  typedef struct packed {
    logic [9:0] off_level;
    logic [9:0] low_level;
    logic [9:0] medium_level;
    logic [7:0] turn_off_delay;
  } cfg_t;

  typedef struct packed {
    logic [1:0] speed;
    logic [1:0] spray;
    logic       wait_flag;
    logic [7:0] elapsed;
  } state_t;

endpackage

>>> rtl/rain_wiper_speed_controller.sv
// Rain wiper speed controller: input register, one pass of step logic, result register.
// Each item passes from the input register through the step logic into the result register,
// where it is held until it transfers out.
// Throughput: one item per cycle; a full input register stalls only while out_stall holds
// the result register.
// Reset (synchronous, rst_n low): both stages empty, speed and spray off, no wait pending,
// thresholds 800/500/200 and a turn-off delay of 10 ticks.
`timescale 1ns / 1ps

module rain_wiper_speed_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rwsc_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rwsc_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [rwsc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [rwsc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rwsc_pkg::*;

  cfg_t      cfg;
  logic      in_valid_r;
  in_item_t  in_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  state_t    state_r;
  state_t    state_nxt;
  out_item_t res;
  logic      adv;
  logic      in_take;

  rwsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rwsc_step u_step (
    .cur  (state_r),
    .item (in_data_r),
    .cfg  (cfg),
    .nxt  (state_nxt),
    .res  (res)
  );

  // Advance the held item into the result register when that register frees up
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a held result");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(state_r))
    else $error("controller state changed without a transfer");

  a_remain_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.waiting_off) |-> (out_data_r.remaining_seconds == 8'd0))
    else $error("remaining seconds nonzero while not waiting");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !in_valid_r))
    else $error("pipeline not empty after reset");
`endif

endmodule

>>> rtl/rwsc_cfg_regs.sv
// Configuration register file for the rain wiper speed controller.
// Depends on rwsc_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module rwsc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rwsc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [rwsc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output rwsc_pkg::cfg_t                   cfg
);
  import rwsc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_OFF_LEVEL:      cfg_nxt.off_level      = cfg_wdata;
        REG_LOW_LEVEL:      cfg_nxt.low_level      = cfg_wdata;
        REG_MEDIUM_LEVEL:   cfg_nxt.medium_level   = cfg_wdata;
        REG_TURN_OFF_DELAY: cfg_nxt.turn_off_delay = cfg_wdata[7:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.off_level      <= OFF_LEVEL_RST;
      cfg_r.low_level      <= LOW_LEVEL_RST;
      cfg_r.medium_level   <= MEDIUM_LEVEL_RST;
      cfg_r.turn_off_delay <= TURN_OFF_DELAY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/rwsc_step.sv
// Next-state and result logic for one item of the wiper controller.
// Purely combinational; depends on rwsc_pkg for codes and struct types.
`timescale 1ns / 1ps

module rwsc_step (
  input  rwsc_pkg::state_t    cur,
  input  rwsc_pkg::in_item_t  item,
  input  rwsc_pkg::cfg_t      cfg,
  output rwsc_pkg::state_t    nxt,
  output rwsc_pkg::out_item_t res
);
  import rwsc_pkg::*;

  logic [1:0] target;
  logic       spray_ok;

  // First matching threshold wins, whatever the register values
  always_comb begin
    if (item.light_level >= cfg.off_level) begin
      target = SPD_OFF;
    end else if (item.light_level >= cfg.low_level) begin
      target = SPD_LOW;
    end else if (item.light_level >= cfg.medium_level) begin
      target = SPD_MED;
    end else begin
      target = SPD_HIGH;
    end
  end

  assign spray_ok = item.spray_choice inside {SPRAY_OFF, SPRAY_LIGHT, SPRAY_HEAVY};

  always_comb begin
    nxt = cur;
    case (item.op)
      OP_READING: begin
        if (!item.reading_valid) begin
          nxt.speed     = SPD_LOW;
          nxt.wait_flag = 1'b0;
        end else if (item.rain_burst) begin
          nxt.speed     = SPD_HIGH;
          nxt.wait_flag = 1'b0;
        end else if (target == SPD_OFF && cur.speed != SPD_OFF) begin
          // Delayed turn-off: start the wait, or stop once the delay has passed
          if (!cur.wait_flag) begin
            nxt.wait_flag = 1'b1;
            nxt.elapsed   = '0;
          end else if (cur.elapsed >= cfg.turn_off_delay) begin
            nxt.speed     = SPD_OFF;
            nxt.wait_flag = 1'b0;
          end
        end else begin
          nxt.speed     = target;
          nxt.wait_flag = 1'b0;
        end
      end
      OP_TICK: begin
        if (cur.wait_flag && cur.elapsed != ELAPSED_MAX) begin
          nxt.elapsed = cur.elapsed + 8'd1;
        end
      end
      OP_SET_SPEED: begin
        nxt.speed = item.new_speed;
      end
      OP_SET_SPRAY: begin
        if (spray_ok) begin
          nxt.spray = item.spray_choice;
        end
      end
      OP_SPRAY_WIPE: begin
        if (spray_ok) begin
          nxt.spray = item.spray_choice;
          if (item.spray_choice == SPRAY_LIGHT) begin
            nxt.speed = SPD_LOW;
          end else if (item.spray_choice == SPRAY_HEAVY) begin
            nxt.speed = SPD_MED;
          end
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  always_comb begin
    res.wiper_speed = nxt.speed;
    res.spray_state = nxt.spray;
    res.waiting_off = nxt.wait_flag;
    if (nxt.wait_flag && cfg.turn_off_delay > nxt.elapsed) begin
      res.remaining_seconds = cfg.turn_off_delay - nxt.elapsed;
    end else begin
      res.remaining_seconds = '0;
    end
  end

endmodule

>>> dv/rain_wiper_speed_controller_tb.sv
// Self-checking testbench for rain_wiper_speed_controller: directed table, then random phases.
// Depends on rtl/rwsc_pkg.sv and rtl/rain_wiper_speed_controller.sv; predicts every result.
`timescale 1ns / 1ps

module rain_wiper_speed_controller_tb;
  import rwsc_pkg::*;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam logic [1:0] SPRAY_BAD      = 2'd3;
  localparam logic [9:0] LEVEL_MAX      = 10'd1023;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned DRAIN_CYCLES  = 4;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned NUM_PHASES    = 6;
  localparam int unsigned PHASE_ITEMS   = 205;

  typedef struct {
    bit                    cfg_row;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] wdata;
    in_item_t              item;
    bit                    typed;
    out_item_t             fixed;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cfg_t        cfg_now;
  state_t      wiper_st;
  out_item_t   pending_states[$];
  stim_row_t   stim_table[$];
  bit          idle_on;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned cycle_count = 0;

  rain_wiper_speed_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic logic [1:0] wiper_target(logic [9:0] lvl);
    if (lvl >= cfg_now.off_level) return SPD_OFF;
    if (lvl >= cfg_now.low_level) return SPD_LOW;
    if (lvl >= cfg_now.medium_level) return SPD_MED;
    return SPD_HIGH;
  endfunction

  // Advance the wiper state by one item and return the state it reports.
  function automatic out_item_t advance_wiper(in_item_t it);
    out_item_t  r;
    logic [1:0] tgt;
    case (it.op)
      OP_READING: begin
        if (!it.reading_valid) begin
          wiper_st.speed = SPD_LOW;
          wiper_st.wait_flag = 1'b0;
        end else if (it.rain_burst) begin
          wiper_st.speed = SPD_HIGH;
          wiper_st.wait_flag = 1'b0;
        end else begin
          tgt = wiper_target(it.light_level);
          if (tgt == SPD_OFF && wiper_st.speed != SPD_OFF) begin
            if (!wiper_st.wait_flag) begin
              wiper_st.wait_flag = 1'b1;
              wiper_st.elapsed = '0;
            end else if (wiper_st.elapsed >= cfg_now.turn_off_delay) begin
              wiper_st.speed = SPD_OFF;
              wiper_st.wait_flag = 1'b0;
            end
          end else begin
            wiper_st.speed = tgt;
            wiper_st.wait_flag = 1'b0;
          end
        end
      end
      OP_TICK: begin
        if (wiper_st.wait_flag && wiper_st.elapsed != ELAPSED_MAX)
          wiper_st.elapsed = wiper_st.elapsed + 8'd1;
      end
      OP_SET_SPEED: wiper_st.speed = it.new_speed;
      OP_SET_SPRAY: begin
        if (it.spray_choice != SPRAY_BAD) wiper_st.spray = it.spray_choice;
      end
      OP_SPRAY_WIPE: begin
        if (it.spray_choice != SPRAY_BAD) begin
          wiper_st.spray = it.spray_choice;
          if (it.spray_choice == SPRAY_LIGHT) wiper_st.speed = SPD_LOW;
          else if (it.spray_choice == SPRAY_HEAVY) wiper_st.speed = SPD_MED;
        end
      end
      default: ;
    endcase
    r.wiper_speed = wiper_st.speed;
    r.spray_state = wiper_st.spray;
    r.waiting_off = wiper_st.wait_flag;
    if (wiper_st.wait_flag && cfg_now.turn_off_delay > wiper_st.elapsed)
      r.remaining_seconds = cfg_now.turn_off_delay - wiper_st.elapsed;
    else
      r.remaining_seconds = '0;
    return r;
  endfunction

  function automatic in_item_t mk_in(logic [2:0] op, logic [9:0] lvl, logic vld, logic bst,
                                     logic [1:0] spd, logic [1:0] spr);
    in_item_t it;
    it.op = op;
    it.light_level = lvl;
    it.reading_valid = vld;
    it.rain_burst = bst;
    it.new_speed = spd;
    it.spray_choice = spr;
    return it;
  endfunction

  function automatic out_item_t mk_out(logic [1:0] spd, logic [1:0] spr, logic w,
                                       logic [7:0] rem);
    out_item_t r;
    r.wiper_speed = spd;
    r.spray_state = spr;
    r.waiting_off = w;
    r.remaining_seconds = rem;
    return r;
  endfunction

  function automatic in_item_t rand_item();
    return in_item_t'($urandom);
  endfunction

  // A valid, burst-free reading that lands at or above the off threshold.
  function automatic in_item_t off_reading();
    in_item_t it;
    it = rand_item();
    it.op = OP_READING;
    it.reading_valid = 1'b1;
    it.rain_burst = 1'b0;
    it.light_level = 10'($urandom_range(cfg_now.off_level, LEVEL_MAX));
    return it;
  endfunction

  task automatic add_item(in_item_t it, bit typed, out_item_t fixed);
    stim_row_t row;
    row.cfg_row = 1'b0;
    row.addr = '0;
    row.wdata = '0;
    row.item = it;
    row.typed = typed;
    row.fixed = fixed;
    stim_table.push_back(row);
  endtask

  task automatic add_cfg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] wdata);
    stim_row_t row;
    row.cfg_row = 1'b1;
    row.addr = addr;
    row.wdata = wdata;
    row.item = '0;
    row.typed = 1'b0;
    row.fixed = '0;
    stim_table.push_back(row);
  endtask

  task automatic send_item(in_item_t it, bit typed, out_item_t fixed);
    out_item_t pred;
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = advance_wiper(it);
    pending_states.push_back(typed ? fixed : pred);
    items_sent++;
  endtask

  // Drop valid, drain the pipeline, then write one register.
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] wdata);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_states.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= wdata;
    case (addr)
      REG_OFF_LEVEL:      cfg_now.off_level = wdata;
      REG_LOW_LEVEL:      cfg_now.low_level = wdata;
      REG_MEDIUM_LEVEL:   cfg_now.medium_level = wdata;
      REG_TURN_OFF_DELAY: cfg_now.turn_off_delay = wdata[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_thresholds(logic [9:0] offl, logic [9:0] lowl, logic [9:0] medl,
                                    logic [9:0] dly);
    write_reg(REG_OFF_LEVEL, offl);
    write_reg(REG_LOW_LEVEL, lowl);
    write_reg(REG_MEDIUM_LEVEL, medl);
    write_reg(REG_TURN_OFF_DELAY, dly);
  endtask

  // Mostly rain-stops-then-ticks sequences; the rest is manual ops and noise.
  task automatic run_sequence();
    in_item_t    it;
    int unsigned roll;
    int unsigned n;
    int unsigned k;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      it = rand_item();
      it.op = OP_READING;
      it.reading_valid = 1'b1;
      it.rain_burst = (cfg_now.off_level == 0);
      if (cfg_now.off_level != 0)
        it.light_level = 10'($urandom_range(0, cfg_now.off_level - 1));
      send_item(it, 1'b0, '0);
      send_item(off_reading(), 1'b0, '0);
      if ($urandom_range(0, 19) == 0) n = $urandom_range(250, 270);
      else n = $urandom_range(0, cfg_now.turn_off_delay + 3);
      for (k = 0; k < n; k++) begin
        it = rand_item();
        if ($urandom_range(0, 9) != 0) it.op = OP_TICK;
        else if ($urandom_range(0, 1) == 0) it = off_reading();
        send_item(it, 1'b0, '0);
      end
      send_item(off_reading(), 1'b0, '0);
    end else if (roll < 80) begin
      it = rand_item();
      it.op = 3'($urandom_range(OP_SET_SPEED, OP_SPRAY_WIPE));
      send_item(it, 1'b0, '0);
    end else begin
      send_item(rand_item(), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_states.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        mismatches++;
      end else begin
        want = pending_states.pop_front();
        results_checked++;
        if (out_data.wiper_speed !== want.wiper_speed) begin
          $display("%0t: wiper_speed expected %0d got %0d", $time, want.wiper_speed,
                   out_data.wiper_speed);
          mismatches++;
        end
        if (out_data.spray_state !== want.spray_state) begin
          $display("%0t: spray_state expected %0d got %0d", $time, want.spray_state,
                   out_data.spray_state);
          mismatches++;
        end
        if (out_data.waiting_off !== want.waiting_off) begin
          $display("%0t: waiting_off expected %0d got %0d", $time, want.waiting_off,
                   out_data.waiting_off);
          mismatches++;
        end
        if (out_data.remaining_seconds !== want.remaining_seconds) begin
          $display("%0t: remaining_seconds expected %0d got %0d", $time,
                   want.remaining_seconds, out_data.remaining_seconds);
          mismatches++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up into its input.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && items_sent >= 300) begin
        out_stall <= 1'b1;
        hold_left = HOLD_CYCLES - 1;
        hold_done = 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(0, 99) < 37);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("rain_wiper_speed_controller_tb: FAIL");
    $finish;
  end

  initial begin
    int unsigned ph;
    int unsigned r;
    int unsigned stop_at;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    idle_on = 1'b1;
    items_sent = 0;
    results_checked = 0;
    mismatches = 0;
    cfg_now.off_level = OFF_LEVEL_RST;
    cfg_now.low_level = LOW_LEVEL_RST;
    cfg_now.medium_level = MEDIUM_LEVEL_RST;
    cfg_now.turn_off_delay = TURN_OFF_DELAY_RST;
    wiper_st = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values, forced speeds, threshold edges, spray handling and spare op codes.
    add_item(mk_in(OP_TICK, 10'd0, 1'b0, 1'b0, SPD_OFF, SPRAY_OFF), 1'b1,
             mk_out(SPD_OFF, SPRAY_OFF, 1'b0, 8'd0));
    add_item(mk_in(OP_READING, LEVEL_MAX, 1'b0, 1'b0, SPD_OFF, SPRAY_OFF), 1'b1,
             mk_out(SPD_LOW, SPRAY_OFF, 1'b0, 8'd0));
    add_item(mk_in(OP_READING, 10'd0, 1'b1, 1'b1, SPD_OFF, SPRAY_OFF), 1'b1,
             mk_out(SPD_HIGH, SPRAY_OFF, 1'b0, 8'd0));
    add_item(mk_in(OP_READING, LEVEL_MAX, 1'b1, 1'b0, SPD_OFF, SPRAY_OFF), 1'b1,
             mk_out(SPD_HIGH, SPRAY_OFF, 1'b1, TURN_OFF_DELAY_RST));
    add_item(mk_in(OP_TICK, 10'd0, 1'b0, 1'b0, SPD_OFF, SPRAY_OFF), 1'b0, '0);
    add_item(mk_in(OP_SET_SPEED, 10'd0, 1'b0, 1'b0, SPD_OFF, SPRAY_OFF), 1'b0, '0);
    add_item(mk_in(OP_READING, 10'd800, 1'b1, 1'b0, SPD_OFF, SPRAY_OFF), 1'b0, '0);
    add_item(mk_in(OP_READING, 10'd500, 1'b1, 1'b0, SPD_OFF, SPRAY_OFF), 1'b0, '0);
    add_item(mk_in(OP_READING, 10'd199, 1'b1, 1'b0, SPD_OFF, SPRAY_OFF), 1'b0, '0);
    add_item(mk_in(OP_READING, 10'd200, 1'b1, 1'b0, SPD_OFF, SPRAY_OFF), 1'b0, '0);
    add_item(mk_in(OP_SET_SPRAY, 10'd0, 1'b0, 1'b0, SPD_OFF, SPRAY_BAD), 1'b0, '0);
    add_item(mk_in(OP_SET_SPRAY, 10'd0, 1'b0, 1'b0, SPD_OFF, SPRAY_HEAVY), 1'b0, '0);
    add_item(mk_in(OP_SPRAY_WIPE, 10'd0, 1'b0, 1'b0, SPD_OFF, SPRAY_LIGHT), 1'b0, '0);
    add_item(mk_in(OP_SPRAY_WIPE, 10'd0, 1'b0, 1'b0, SPD_OFF, SPRAY_HEAVY), 1'b0, '0);
    add_item(mk_in(OP_SPRAY_WIPE, 10'd0, 1'b0, 1'b0, SPD_OFF, SPRAY_OFF), 1'b0, '0);
    add_item(mk_in(OP_SPRAY_WIPE, 10'd0, 1'b0, 1'b0, SPD_OFF, SPRAY_BAD), 1'b0, '0);
    for (r = OP_SPARE_FIRST; r <= OP_SPARE_LAST; r++)
      add_item(mk_in(3'(r), LEVEL_MAX, 1'b1, 1'b1, SPD_HIGH, SPRAY_BAD), 1'b0, '0);
    // Zero delay: the second off reading stops the wipers.
    add_cfg(REG_TURN_OFF_DELAY, 10'd0);
    add_item(mk_in(OP_READING, LEVEL_MAX, 1'b1, 1'b0, SPD_OFF, SPRAY_OFF), 1'b1,
             mk_out(SPD_MED, SPRAY_OFF, 1'b1, 8'd0));
    add_item(mk_in(OP_READING, LEVEL_MAX, 1'b1, 1'b0, SPD_OFF, SPRAY_OFF), 1'b1,
             mk_out(SPD_OFF, SPRAY_OFF, 1'b0, 8'd0));
    // Inverted thresholds: the off test still wins first.
    add_cfg(REG_OFF_LEVEL, 10'd100);
    add_cfg(REG_LOW_LEVEL, 10'd300);
    add_cfg(REG_MEDIUM_LEVEL, 10'd600);
    add_item(mk_in(OP_SET_SPEED, 10'd0, 1'b0, 1'b0, SPD_HIGH, SPRAY_OFF), 1'b0, '0);
    add_item(mk_in(OP_READING, 10'd50, 1'b1, 1'b0, SPD_OFF, SPRAY_OFF), 1'b0, '0);
    add_item(mk_in(OP_READING, 10'd400, 1'b1, 1'b0, SPD_OFF, SPRAY_OFF), 1'b0, '0);
    add_item(mk_in(OP_READING, 10'd700, 1'b1, 1'b0, SPD_OFF, SPRAY_OFF), 1'b0, '0);

    foreach (stim_table[i]) begin
      if (stim_table[i].cfg_row) write_reg(stim_table[i].addr, stim_table[i].wdata);
      else send_item(stim_table[i].item, stim_table[i].typed, stim_table[i].fixed);
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: program_thresholds(OFF_LEVEL_RST, LOW_LEVEL_RST, MEDIUM_LEVEL_RST,
                              10'(TURN_OFF_DELAY_RST));
        1: program_thresholds(10'd0, 10'd0, 10'd0, 10'd1);
        2: program_thresholds(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, 10'd255);
        3: program_thresholds(10'd100, 10'd300, 10'd600, 10'd0);
        default: program_thresholds(10'($urandom_range(0, LEVEL_MAX)),
                                    10'($urandom_range(0, LEVEL_MAX)),
                                    10'($urandom_range(0, LEVEL_MAX)),
                                    10'($urandom_range(0, LEVEL_MAX)));
      endcase
      // Last phase runs both sides back to back.
      idle_on = (ph != NUM_PHASES - 1);
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) run_sequence();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_states.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    $display("Sent %0d items, checked %0d results across %0d register settings,",
             items_sent, results_checked, NUM_PHASES + 2);
    $display("with random stalls on both sides and one %0d-cycle receiver hold-off.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("rain_wiper_speed_controller_tb: PASS");
    end else begin
      $display("rain_wiper_speed_controller_tb: FAIL");
    end
    $finish;
  end

endmodule
